// File: src/plo_pkg.sv
// shared types and codes for the positional ordered list
package plo_pkg;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_AT    = 3'd1,
        OP_INS_END   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_AT    = 3'd4,
        OP_DEL_END   = 3'd5,
        OP_SEARCH    = 3'd6,
        OP_DUMP      = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_EMIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DUMP_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
        logic [4:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] item_value;
        logic [4:0]         item_position;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// File: src/plo_store.sv
// element store: one write port and one registered read port
module plo_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  plo_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic [WIDTH-1:0] o_rd_data
);
    import plo_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/plo_ctrl.sv
// sequencer: decodes an operation and steps the shared index over the store
module plo_ctrl #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32,
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  plo_pkg::t_in_item      i_in_item,
    input  logic                   i_out_space,
    output logic                   o_emit,
    output plo_pkg::t_out_item     o_emit_item,
    output plo_pkg::t_mem_ctl      o_mem,
    output logic [AW-1:0]          o_rd_addr,
    output logic [AW-1:0]          o_wr_addr,
    output logic [VALUE_WIDTH-1:0] o_wr_data,
    input  logic [VALUE_WIDTH-1:0] i_rd_data
);
    import plo_pkg::*;

    localparam int XW = ((CW > 5) ? CW : 5) + 1;

    t_state                 r_state, n_state;
    t_op                    r_op, n_op;
    t_status                r_status, n_status;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_idx, n_idx;
    logic [CW-1:0]          r_tgt, n_tgt;
    logic [4:0]             r_rpos, n_rpos;

    logic [CW-1:0] w_idx_up;
    logic [CW-1:0] w_idx_dn;
    logic [CW-1:0] w_tgt;
    logic [XW-1:0] w_pos;
    logic [XW-1:0] w_cnt;
    logic [4:0]    w_item_pos;
    logic          w_ins;
    logic          w_last;
    t_op           w_in_op;

    assign w_idx_up   = r_idx + CW'(1);
    assign w_idx_dn   = r_idx - CW'(1);
    assign w_pos      = XW'(i_in_item.position);
    assign w_cnt      = XW'(r_count);
    assign w_item_pos = 5'(w_idx_up);
    assign w_last     = (w_idx_up == r_count);
    assign w_in_op    = t_op'(i_in_item.operation);
    assign w_ins      = (r_op == OP_INS_FRONT) || (r_op == OP_INS_AT) || (r_op == OP_INS_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_op     <= n_op;
        r_status <= n_status;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_tgt    <= n_tgt;
        r_rpos   <= n_rpos;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_status    = r_status;
        n_val       = r_val;
        n_count     = r_count;
        n_idx       = r_idx;
        n_tgt       = r_tgt;
        n_rpos      = r_rpos;
        w_tgt       = '0;
        o_in_ready  = 1'b0;
        o_emit      = 1'b0;
        o_emit_item = '0;
        o_mem       = '0;
        o_rd_addr   = AW'(r_idx);
        o_wr_addr   = AW'(r_idx);
        o_wr_data   = i_rd_data;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op     = w_in_op;
                    n_val    = VALUE_WIDTH'(i_in_item.value);
                    n_status = ST_OK;
                    n_rpos   = '0;
                    case (w_in_op)
                        OP_INS_FRONT, OP_INS_AT, OP_INS_END: begin
                            if (w_in_op == OP_INS_END) begin
                                w_tgt = r_count;
                            end else if (w_in_op == OP_INS_AT) begin
                                w_tgt = CW'(w_pos - XW'(1));
                            end
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_EMIT;
                            end else if (w_in_op == OP_INS_AT &&
                                         (w_pos == '0 || w_pos > w_cnt + XW'(1))) begin
                                n_status = ST_RANGE;
                                n_state  = S_EMIT;
                            end else begin
                                n_tgt   = w_tgt;
                                n_idx   = r_count;
                                n_state = (r_count > w_tgt) ? S_SHIFT_RD : S_PUT;
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_AT, OP_DEL_END: begin
                            if (w_in_op == OP_DEL_END) begin
                                w_tgt = r_count - CW'(1);
                            end else if (w_in_op == OP_DEL_AT) begin
                                w_tgt = CW'(w_pos - XW'(1));
                            end
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_EMIT;
                            end else if (w_in_op == OP_DEL_AT &&
                                         (w_pos == '0 || w_pos > w_cnt)) begin
                                n_status = ST_RANGE;
                                n_state  = S_EMIT;
                            end else begin
                                n_idx   = w_tgt;
                                n_count = r_count - CW'(1);
                                n_state = (w_tgt < r_count - CW'(1)) ? S_SHIFT_RD : S_EMIT;
                            end
                        end
                        OP_SEARCH: begin
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                                n_state  = S_EMIT;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        OP_DUMP: begin
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_EMIT;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SHIFT_RD: begin
                o_mem.rd_en = 1'b1;
                o_rd_addr   = w_ins ? AW'(w_idx_dn) : AW'(w_idx_up);
                n_state     = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_mem.wr_en = 1'b1;
                if (w_ins) begin
                    n_idx   = w_idx_dn;
                    n_state = (w_idx_dn > r_tgt) ? S_SHIFT_RD : S_PUT;
                end else begin
                    n_idx   = w_idx_up;
                    n_state = (w_idx_up < r_count) ? S_SHIFT_RD : S_EMIT;
                end
            end
            S_PUT: begin
                o_mem.wr_en = 1'b1;
                o_wr_addr   = AW'(r_tgt);
                o_wr_data   = r_val;
                n_count     = r_count + CW'(1);
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_space) begin
                    o_emit                    = 1'b1;
                    o_emit_item.status        = r_status;
                    o_emit_item.item_position = r_rpos;
                    o_emit_item.last          = 1'b1;
                    n_state                   = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                o_mem.rd_en = 1'b1;
                n_state     = (r_op == OP_DUMP) ? S_DUMP_OUT : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_rd_data == r_val) begin
                    n_status = ST_OK;
                    n_rpos   = w_item_pos;
                    n_state  = S_EMIT;
                end else if (w_last) begin
                    n_status = ST_NOT_FOUND;
                    n_rpos   = '0;
                    n_state  = S_EMIT;
                end else begin
                    n_idx   = w_idx_up;
                    n_state = S_SCAN_RD;
                end
            end
            S_DUMP_OUT: begin
                if (i_out_space) begin
                    o_emit                    = 1'b1;
                    o_emit_item.status        = ST_OK;
                    o_emit_item.item_value    = 32'(i_rd_data);
                    o_emit_item.item_position = w_item_pos;
                    o_emit_item.last          = w_last;
                    n_idx                     = w_idx_up;
                    n_state                   = w_last ? S_IDLE : S_SCAN_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/positional_ordered_list_top.sv
// top level of the positional ordered list with its output register
//
// channel   direction  signals                                payload
// in        input      i_in_valid / o_in_ready                 t_in_item
// out       output     o_out_valid / i_out_ready               t_out_item
//
// work per item, n = count, k = 0-based target index:
//   insert moves elements k..n-1 up then writes, delete moves k+1..n-1 down,
//   search reads up to a match, dump emits all n; a result waits on a full output
// every element move or look goes through the store's one read and one write port
// synchronous active-low reset empties the list; the store needs no clearing
// a result waits in the output register while the next step runs; sequencer holds when full
module positional_ordered_list_top #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  plo_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output plo_pkg::t_out_item o_out_item
);
    import plo_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    t_mem_ctl               w_mem;
    logic [AW-1:0]          w_rd_addr;
    logic [AW-1:0]          w_wr_addr;
    logic [VALUE_WIDTH-1:0] w_wr_data;
    logic [VALUE_WIDTH-1:0] w_rd_data;
    logic                   w_emit;
    t_out_item              w_emit_item;
    logic                   w_space;

    logic                   r_out_valid;
    t_out_item              r_out_item;

    assign w_space = !r_out_valid || i_out_ready;

    plo_ctrl #(
        .CAPACITY   (CAPACITY),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_out_space(w_space),
        .o_emit     (w_emit),
        .o_emit_item(w_emit_item),
        .o_mem      (w_mem),
        .o_rd_addr  (w_rd_addr),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .i_rd_data  (w_rd_data)
    );

    plo_store #(
        .DEPTH(CAPACITY),
        .WIDTH(VALUE_WIDTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_ctl    (w_mem),
        .i_rd_addr(w_rd_addr),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .o_rd_data(w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_emit) begin
            r_out_item <= w_emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_emit_has_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && r_out_valid |-> i_out_ready)
        else $error("result overwrites a waiting item");

    a_no_emit_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_emit)
        else $error("result produced while accepting a new item");

    a_error_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |->
            o_out_item.last && o_out_item.item_value == '0)
        else $error("error result not final or carries a value");

    a_emit_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> o_out_valid)
        else $error("emitted result not presented");

endmodule

// File: tb/positional_ordered_list_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the positional ordered list: directed table then random ops
module positional_ordered_list_top_test;
    import plo_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int N_DIRECTED   = 23;
    localparam int N_RANDOM     = 160;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        t_op                op;
        logic signed [31:0] val;
        logic [4:0]         pos;
        bit                 fixed;
        t_status            st;
    } t_list_case;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    logic signed [31:0] list_q[$];
    t_out_item          pending_results[$];
    int                 errors      = 0;
    int                 burst_left  = 0;
    int                 idle_cycles = 0;
    int                 rx_mode     = 0;
    int                 rx_stall    = 0;
    int                 rx_cycle    = 0;

    t_list_case directed_ops [N_DIRECTED] = '{
        '{OP_DUMP,      32'sd0,           5'd0,  1'b1, ST_EMPTY},
        '{OP_DEL_FRONT, 32'sd0,           5'd0,  1'b1, ST_EMPTY},
        '{OP_DEL_AT,    32'sd0,           5'd1,  1'b1, ST_EMPTY},
        '{OP_DEL_END,   32'sd0,           5'd0,  1'b1, ST_EMPTY},
        '{OP_SEARCH,    32'sd0,           5'd0,  1'b1, ST_NOT_FOUND},
        '{OP_INS_AT,    32'sd5,           5'd0,  1'b1, ST_RANGE},
        '{OP_INS_AT,    32'sd5,           5'd2,  1'b1, ST_RANGE},
        '{OP_INS_AT,    32'sd5,           5'd31, 1'b1, ST_RANGE},
        '{OP_INS_AT,    32'sh7fff_ffff,   5'd1,  1'b1, ST_OK},
        '{OP_INS_FRONT, 32'sh8000_0000,   5'd31, 1'b1, ST_OK},
        '{OP_INS_END,   -32'sd1,          5'd0,  1'b1, ST_OK},
        '{OP_INS_AT,    32'sd0,           5'd2,  1'b0, ST_OK},
        '{OP_SEARCH,    32'sh7fff_ffff,   5'd0,  1'b0, ST_OK},
        '{OP_SEARCH,    -32'sd1,          5'd31, 1'b0, ST_OK},
        '{OP_DUMP,      32'sd0,           5'd0,  1'b0, ST_OK},
        '{OP_DEL_AT,    32'sd0,           5'd0,  1'b1, ST_RANGE},
        '{OP_DEL_AT,    32'sd0,           5'd5,  1'b1, ST_RANGE},
        '{OP_DEL_AT,    32'sd0,           5'd2,  1'b0, ST_OK},
        '{OP_DEL_END,   32'sd0,           5'd0,  1'b0, ST_OK},
        '{OP_DEL_FRONT, 32'sd0,           5'd0,  1'b0, ST_OK},
        '{OP_SEARCH,    32'sd12345,       5'd0,  1'b1, ST_NOT_FOUND},
        '{OP_DEL_AT,    32'sd0,           5'd1,  1'b0, ST_OK},
        '{OP_DUMP,      32'sd0,           5'd0,  1'b1, ST_EMPTY}
    };

    positional_ordered_list_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    function automatic void list_apply(input t_in_item it, ref t_out_item res[$]);
        t_op       op;
        int        cnt;
        int        hit;
        t_out_item r;
        op  = t_op'(it.operation);
        cnt = list_q.size();
        hit = 0;
        r   = '{status: ST_OK, item_value: '0, item_position: '0, last: 1'b1};
        case (op)
            OP_INS_FRONT, OP_INS_AT, OP_INS_END: begin
                if (cnt >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (op == OP_INS_AT && (it.position < 1 || it.position > cnt + 1)) begin
                    r.status = ST_RANGE;
                end else if (op == OP_INS_FRONT) begin
                    list_q.push_front(it.value);
                end else if (op == OP_INS_END) begin
                    list_q.push_back(it.value);
                end else begin
                    list_q.insert(int'(it.position) - 1, it.value);
                end
                res.push_back(r);
            end
            OP_DEL_FRONT, OP_DEL_AT, OP_DEL_END: begin
                if (cnt == 0) begin
                    r.status = ST_EMPTY;
                end else if (op == OP_DEL_AT && (it.position < 1 || it.position > cnt)) begin
                    r.status = ST_RANGE;
                end else if (op == OP_DEL_FRONT) begin
                    list_q.delete(0);
                end else if (op == OP_DEL_END) begin
                    list_q.delete(cnt - 1);
                end else begin
                    list_q.delete(int'(it.position) - 1);
                end
                res.push_back(r);
            end
            OP_SEARCH: begin
                for (int i = 0; i < cnt && hit == 0; i++) begin
                    if (list_q[i] == it.value) hit = i + 1;
                end
                r.status        = (hit != 0) ? ST_OK : ST_NOT_FOUND;
                r.item_position = 5'(hit);
                res.push_back(r);
            end
            default: begin
                if (cnt == 0) begin
                    r.status = ST_EMPTY;
                    res.push_back(r);
                end
                for (int i = 0; i < cnt; i++) begin
                    r.item_value    = list_q[i];
                    r.item_position = 5'(i + 1);
                    r.last          = (i == cnt - 1);
                    res.push_back(r);
                end
            end
        endcase
    endfunction

    task automatic send_item(input t_in_item it, input bit fixed, input t_status fixed_st);
        t_out_item res[$];
        int        gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        list_apply(it, res);
        if (fixed) begin
            res.delete();
            res.push_back('{status: fixed_st, item_value: '0, item_position: '0, last: 1'b1});
        end
        foreach (res[j]) pending_results.push_back(res[j]);
    endtask

    // receiver stall pattern: out_ready drops at random under a stall mode that is re-picked at random
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 2);
        if (rx_stall > 0) begin
            rx_stall--;
            out_ready <= 1'b0;
        end else if (rx_mode == 1 && $urandom_range(0, 3) == 0) begin
            rx_stall = $urandom_range(0, 2);
            out_ready <= 1'b0;
        end else if (rx_mode == 2 && $urandom_range(0, 1) == 0) begin
            rx_stall = $urandom_range(0, 7);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: %p", o_out_item);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_out_item.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_out_item.status);
                    errors++;
                end
                if (o_out_item.item_value !== exp_r.item_value) begin
                    $error("item_value: expected %0d, got %0d",
                           exp_r.item_value, o_out_item.item_value);
                    errors++;
                end
                if (o_out_item.item_position !== exp_r.item_position) begin
                    $error("item_position: expected %0d, got %0d",
                           exp_r.item_position, o_out_item.item_position);
                    errors++;
                end
                if (o_out_item.last !== exp_r.last) begin
                    $error("last: expected %0b, got %0b", exp_r.last, o_out_item.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_in_item it;
        int       cnt;
        int       r;
        int       phase;
        int       ins_cut;
        int       del_cut;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_ops[i]) begin
            it.operation = directed_ops[i].op;
            it.value     = directed_ops[i].val;
            it.position  = directed_ops[i].pos;
            send_item(it, directed_ops[i].fixed, directed_ops[i].st);
        end

        // grow, mixed and shrink phases so the list runs from empty to full and back
        for (int n = 0; n < N_RANDOM; n++) begin
            cnt     = list_q.size();
            phase   = (n / 30) % 3;
            r       = $urandom_range(0, 99);
            ins_cut = (phase == 0) ? 75 : (phase == 1) ? 40 : 20;
            del_cut = (phase == 0) ? 85 : 75;
            if (r < ins_cut) begin
                it.operation = t_op'(int'(OP_INS_FRONT) + $urandom_range(0, 2));
            end else if (r < del_cut) begin
                it.operation = t_op'(int'(OP_DEL_FRONT) + $urandom_range(0, 2));
            end else if (r < 93) begin
                it.operation = OP_SEARCH;
            end else begin
                it.operation = OP_DUMP;
            end
            case ($urandom_range(0, 7))
                0:       it.value = 32'sh8000_0000;
                1:       it.value = 32'sh7fff_ffff;
                2, 3:    it.value = $urandom_range(0, 15);
                default: it.value = $urandom;
            endcase
            if (it.operation == OP_SEARCH && cnt > 0 && $urandom_range(0, 3) != 0) begin
                it.value = list_q[$urandom_range(0, cnt - 1)];
            end
            it.position = 5'($urandom_range(0, 31));
            if (it.operation == OP_INS_AT) begin
                if ($urandom_range(0, 9) != 0) begin
                    it.position = 5'($urandom_range(1, cnt + 1));
                end else begin
                    it.position = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(cnt + 2, 31));
                end
            end else if (it.operation == OP_DEL_AT) begin
                if (cnt > 0 && $urandom_range(0, 9) != 0) begin
                    it.position = 5'($urandom_range(1, cnt));
                end else begin
                    it.position = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(cnt + 1, 31));
                end
            end
            send_item(it, 1'b0, ST_OK);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
